// File: hdl/concentric_square_to_disk_map_unit_macros.svh
// Assertion shorthands shared by the mapping unit and its divider cell.
`ifndef CONCENTRIC_SQUARE_TO_DISK_MAP_UNIT_MACROS_SVH
`define CONCENTRIC_SQUARE_TO_DISK_MAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CSDM_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSDM_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/csdm_pkg.sv
package csdm_pkg;

  // Default sizes of the datapath.
  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Width of the Q1.30 ratio quotient and number of divider cells.
  localparam int QUO_BITS = 31;

  // Angle and gain constants in Q30.
  localparam logic [29:0] PI_QUARTER_Q30 = 30'd843314857;
  localparam logic [29:0] GAIN_Q30       = 30'd652032874;

  // Quarter-turn codes applied after the rotation.
  localparam logic [1:0] TURN_ZERO  = 2'd0;
  localparam logic [1:0] TURN_ONE   = 2'd1;
  localparam logic [1:0] TURN_TWO   = 2'd2;
  localparam logic [1:0] TURN_THREE = 2'd3;

  // Side information that travels with each request.
  typedef struct packed {
    logic       neg;
    logic [1:0] turns;
    logic       last;
  } side_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] val;
    case (i)
      0: val = 32'd843314857;
      1: val = 32'd497837829;
      2: val = 32'd263043837;
      3: val = 32'd133525159;
      4: val = 32'd67021687;
      5: val = 32'd33543516;
      6: val = 32'd16775851;
      7: val = 32'd8388437;
      8: val = 32'd4194283;
      9: val = 32'd2097149;
      default: val = (i < 30) ? (32'd1 << (30 - i)) : 32'd0;
    endcase
    return val;
  endfunction

endpackage

// File: hdl/csdm_div_cell.sv
`include "concentric_square_to_disk_map_unit_macros.svh"

module csdm_div_cell
  import csdm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter bit FIRST     = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 up_valid,
  input  logic [FRAC_BITS:0]   up_rem,
  input  logic [FRAC_BITS:0]   up_den,
  input  logic [QUO_BITS-1:0]  up_quo,
  input  side_t                up_side,
  output logic                 dn_valid,
  output logic [FRAC_BITS:0]   dn_rem,
  output logic [FRAC_BITS:0]   dn_den,
  output logic [QUO_BITS-1:0]  dn_quo,
  output side_t                dn_side
);

  logic [FRAC_BITS+1:0] trial;
  logic [FRAC_BITS+1:0] diff;
  logic                 ge;

  // One restoring step: shift the remainder in (except for the leading bit) and try a subtract.
  always_comb begin
    trial = FIRST ? {1'b0, up_rem} : {up_rem, 1'b0};
    ge    = trial >= {1'b0, up_den};
    diff  = trial - {1'b0, up_den};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  // Payload moves with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      dn_rem  <= ge ? diff[FRAC_BITS:0] : trial[FRAC_BITS:0];
      dn_den  <= up_den;
      dn_quo  <= {up_quo[QUO_BITS-2:0], ge};
      dn_side <= up_side;
    end
  end

  // The partial remainder always stays below the divisor.
  `CSDM_ASSERT_IMP(a_rem_below_den, clk, rst, dn_valid && (dn_den != '0), dn_rem < dn_den,
    "divider remainder not below divisor")
  // A request handed in while the chain moves shows up in the next cell.
  `CSDM_ASSERT_NXT(a_valid_moves, clk, rst, en && up_valid, dn_valid,
    "divider cell dropped a request")
  // A frozen chain keeps its requests in place.
  `CSDM_ASSERT_NXT(a_frozen_holds, clk, rst, !en, $stable(dn_valid),
    "divider cell changed while frozen")

endmodule

// File: hdl/csdm_cordic_cell.sv
module csdm_cordic_cell
  import csdm_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               up_valid,
  input  logic signed [33:0] up_x,
  input  logic signed [33:0] up_y,
  input  logic signed [32:0] up_z,
  input  side_t              up_side,
  output logic               dn_valid,
  output logic signed [33:0] dn_x,
  output logic signed [33:0] dn_y,
  output logic signed [32:0] dn_z,
  output side_t              dn_side
);

  localparam logic [31:0] ATAN = atan_q30(STAGE);

  logic signed [33:0] tx;
  logic signed [33:0] ty;
  logic signed [32:0] at;
  logic               dir;

  // Floor shifts of both coordinates and the rotation direction.
  always_comb begin
    tx  = up_x >>> STAGE;
    ty  = up_y >>> STAGE;
    at  = signed'({1'b0, ATAN});
    dir = !up_z[32];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  // One micro-rotation toward zero residual angle.
  always_ff @(posedge clk) begin
    if (en) begin
      dn_x    <= dir ? (up_x - ty) : (up_x + ty);
      dn_y    <= dir ? (up_y + tx) : (up_y - tx);
      dn_z    <= dir ? (up_z - at) : (up_z + at);
      dn_side <= up_side;
    end
  end

endmodule

// File: hdl/concentric_square_to_disk_map_unit.sv
// Throughput: one request per cycle while the skid stage is empty; the 31-cell divider
// chain and the CORDIC cell chain each advance one step per cycle, and all freeze while
// the skid stage holds a request.
// Reset: rst is synchronous and active high; it empties the pipeline, the output
// register and the skid stage, and sets near_zero_limit to 0.
`include "concentric_square_to_disk_map_unit_macros.svh"

module concentric_square_to_disk_map_unit
  import csdm_pkg::*;
#(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   near_zero_limit_we,
  input  logic [7:0]             near_zero_limit_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FRAC_BITS:0]     square_x,
  input  logic [FRAC_BITS:0]     square_y,
  input  logic                   last_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FRAC_BITS+1:0]   disk_x,
  output logic [FRAC_BITS+1:0]   disk_y,
  output logic                   last_out
);

  localparam int IW   = FRAC_BITS + 1;
  localparam int SW   = FRAC_BITS + 2;
  localparam int BACK = 30 - FRAC_BITS;
  localparam logic [IW-1:0]        OneU = IW'(1) << FRAC_BITS;
  localparam logic signed [33:0]   OneW = 34'(1) << FRAC_BITS;

  logic [7:0] near_zero_limit;
  logic       en;
  logic       skid_valid;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= 8'd0;
    end else if (near_zero_limit_we) begin
      near_zero_limit <= near_zero_limit_data;
    end
  end

  // The pipeline moves whenever the skid stage is empty.
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // Clamp, rescale to [-1,1] and pick the sector.
  logic [IW-1:0]        cux, cuy, absx, absy, num, den;
  logic signed [SW-1:0] x, y;
  side_t                side0;

  always_comb begin
    cux  = (square_x > OneU) ? OneU : square_x;
    cuy  = (square_y > OneU) ? OneU : square_y;
    x    = signed'({cux, 1'b0}) - signed'(SW'(OneU));
    y    = signed'({cuy, 1'b0}) - signed'(SW'(OneU));
    absx = x[SW-1] ? IW'(-x) : IW'(x);
    absy = y[SW-1] ? IW'(-y) : IW'(y);
    side0.last = last_sample;
    if (x > -y) begin
      if (x > y) begin
        den = absx; num = absy; side0.neg = y[SW-1]; side0.turns = TURN_ZERO;
      end else begin
        den = absy; num = absx; side0.neg = (x > 0); side0.turns = TURN_ONE;
      end
    end else if (x < y) begin
      den = absx; num = absy; side0.neg = (y > 0); side0.turns = TURN_TWO;
    end else begin
      den = absy;
      if (absy > {{(IW-8){1'b0}}, near_zero_limit}) begin
        num = absx; side0.neg = x[SW-1]; side0.turns = TURN_THREE;
      end else begin
        // Near-zero y: zero angle and no quarter turn.
        num = '0; side0.neg = 1'b0; side0.turns = TURN_ZERO;
      end
    end
  end

  // Divider chain: entry 0 is the sector register, entry k+1 the output of cell k.
  logic                d_valid [0:QUO_BITS];
  logic [IW-1:0]       d_rem   [0:QUO_BITS];
  logic [IW-1:0]       d_den   [0:QUO_BITS];
  logic [QUO_BITS-1:0] d_quo   [0:QUO_BITS];
  side_t               d_side  [0:QUO_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (en) begin
      d_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rem[0]  <= num;
      d_den[0]  <= den;
      d_quo[0]  <= '0;
      d_side[0] <= side0;
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    csdm_div_cell #(
      .FRAC_BITS (FRAC_BITS),
      .FIRST     (k == 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .up_valid (d_valid[k]),
      .up_rem   (d_rem[k]),
      .up_den   (d_den[k]),
      .up_quo   (d_quo[k]),
      .up_side  (d_side[k]),
      .dn_valid (d_valid[k+1]),
      .dn_rem   (d_rem[k+1]),
      .dn_den   (d_den[k+1]),
      .dn_quo   (d_quo[k+1]),
      .dn_side  (d_side[k+1])
    );
  end

  // Angle and start-value products.
  logic            m_valid;
  logic [60:0]     th_prod;
  logic [IW+29:0]  cx_prod;
  side_t           m_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= d_valid[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_prod <= 61'(d_quo[QUO_BITS]) * 61'(PI_QUARTER_Q30);
      cx_prod <= (IW+30)'(d_den[QUO_BITS]) * (IW+30)'(GAIN_Q30);
      m_side  <= d_side[QUO_BITS];
    end
  end

  // Round the products into the CORDIC start values.
  logic [60:0]    th_sum;
  logic [IW+29:0] cx_sum;
  logic [32:0]    th_mag;

  always_comb begin
    th_sum = th_prod + (61'(1) << 29);
    cx_sum = cx_prod + ((IW+30)'(1) << (FRAC_BITS - 1));
    th_mag = {3'b000, th_sum[59:30]};
  end

  logic               c_valid [0:CORDIC_STAGES];
  logic signed [33:0] c_x     [0:CORDIC_STAGES];
  logic signed [33:0] c_y     [0:CORDIC_STAGES];
  logic signed [32:0] c_z     [0:CORDIC_STAGES];
  side_t              c_side  [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (en) begin
      c_valid[0] <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x[0]    <= signed'({4'b0000, cx_sum[FRAC_BITS+29:FRAC_BITS]});
      c_y[0]    <= '0;
      c_z[0]    <= m_side.neg ? -signed'(th_mag) : signed'(th_mag);
      c_side[0] <= m_side;
    end
  end

  // CORDIC rotation chain.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    csdm_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .up_valid (c_valid[k]),
      .up_x     (c_x[k]),
      .up_y     (c_y[k]),
      .up_z     (c_z[k]),
      .up_side  (c_side[k]),
      .dn_valid (c_valid[k+1]),
      .dn_x     (c_x[k+1]),
      .dn_y     (c_y[k+1]),
      .dn_z     (c_z[k+1]),
      .dn_side  (c_side[k+1])
    );
  end

  // Round back to the output format.
  logic signed [33:0] rx, ry;

  if (BACK > 0) begin : g_round
    always_comb begin
      rx = (c_x[CORDIC_STAGES] + (34'sd1 <<< (BACK - 1))) >>> BACK;
      ry = (c_y[CORDIC_STAGES] + (34'sd1 <<< (BACK - 1))) >>> BACK;
    end
  end else begin : g_noround
    always_comb begin
      rx = c_x[CORDIC_STAGES];
      ry = c_y[CORDIC_STAGES];
    end
  end

  // Quarter turn and saturation.
  logic signed [33:0] tx, ty, sx, sy;
  side_t              fs;

  always_comb begin
    fs = c_side[CORDIC_STAGES];
    case (fs.turns)
      TURN_ONE:   begin tx = -ry; ty = rx;  end
      TURN_TWO:   begin tx = -rx; ty = -ry; end
      TURN_THREE: begin tx = ry;  ty = -rx; end
      default:    begin tx = rx;  ty = ry;  end
    endcase
    sx = (tx > OneW) ? OneW : ((tx < -OneW) ? -OneW : tx);
    sy = (ty > OneW) ? OneW : ((ty < -OneW) ? -OneW : ty);
  end

  // Output register with a skid stage behind it.
  logic          e_valid;
  logic          o_valid;
  logic          take;
  logic [SW-1:0] o_x, o_y, s_x, s_y;
  logic          o_last, s_last;

  assign e_valid = c_valid[CORDIC_STAGES];
  assign take    = !o_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        o_valid    <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (take) begin
      o_valid <= e_valid;
    end else if (e_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        o_x    <= s_x;
        o_y    <= s_y;
        o_last <= s_last;
      end
    end else if (take) begin
      o_x    <= sx[SW-1:0];
      o_y    <= sy[SW-1:0];
      o_last <= fs.last;
    end else begin
      s_x    <= sx[SW-1:0];
      s_y    <= sy[SW-1:0];
      s_last <= fs.last;
    end
  end

  assign out_valid = o_valid;
  assign disk_x    = o_x;
  assign disk_y    = o_y;
  assign last_out  = o_last;

  // A request in the skid stage always has one ahead of it in the output register.
  `CSDM_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, o_valid,
    "skid holds a request with the output register empty")
  // A finished request that meets a held output is caught by the skid stage.
  `CSDM_ASSERT_NXT(a_skid_catches, clk, rst, o_valid && out_stall && !skid_valid && e_valid,
    skid_valid, "finished request lost at held output")
  // A held result stays valid and unchanged.
  `CSDM_ASSERT_NXT(a_out_held, clk, rst, o_valid && out_stall,
    o_valid && $stable(o_x) && $stable(o_y), "held result changed")

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import csdm_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;

  // One mapped point on the disk.
  typedef struct {
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic               last;
  } disk_pt_t;

  // One row of the directed table.
  typedef struct {
    logic [16:0]        sx;
    logic [16:0]        sy;
    logic               last;
    bit                 typed;
    logic signed [17:0] ex;
    logic signed [17:0] ey;
  } sample_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        near_zero_limit_we = 1'b0;
  logic [7:0]  near_zero_limit_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [16:0] square_x = '0;
  logic [16:0] square_y = '0;
  logic        last_sample = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [17:0] disk_x;
  logic [17:0] disk_y;
  logic        last_out;

  disk_pt_t    pending_pts[$];
  logic [7:0]  zero_limit = '0;
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          send_gaps = 1'b1;

  concentric_square_to_disk_map_unit u_top (
    .clk(clk), .rst(rst),
    .near_zero_limit_we(near_zero_limit_we),
    .near_zero_limit_data(near_zero_limit_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .square_x(square_x), .square_y(square_y), .last_sample(last_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .disk_x(disk_x), .disk_y(disk_y), .last_out(last_out)
  );

  always #10 clk = ~clk;

  // Quotient in Q2.30 with its magnitude truncated toward zero.
  function automatic longint div_q30(longint num, longint den);
    longint unsigned an, ad, m;
    if (den == 0) return 0;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    m = (an << 30) / ad;
    return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  // Predicts the disk point for one square sample.
  function automatic disk_pt_t map_point(logic [16:0] sx, logic [16:0] sy, logic lst,
                                         logic [7:0] lim);
    longint atan_tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149};
    longint ux, uy, x, y, r, q, theta, cx, cy, z, tx, ty, ox, oy, ang;
    longint unsigned mag;
    int turns;
    disk_pt_t p;
    ux = (sx > 65536) ? 65536 : sx;
    uy = (sy > 65536) ? 65536 : sy;
    x = 2 * ux - 65536;
    y = 2 * uy - 65536;
    if (x > -y) begin
      if (x > y) begin
        r = x; q = div_q30(y, x); turns = 0;
      end else begin
        r = y; q = -div_q30(x, y); turns = 1;
      end
    end else if (x < y) begin
      r = -x; q = div_q30(y, x); turns = 2;
    end else begin
      r = -y;
      if (((y < 0) ? -y : y) > longint'(lim)) begin
        q = -div_q30(x, y); turns = 3;
      end else begin
        q = 0; turns = 0;
      end
    end
    mag = (q < 0) ? -q : q;
    mag = (mag * 64'd843314857 + (64'd1 << 29)) >> 30;
    theta = (q < 0) ? -longint'(mag) : longint'(mag);
    cx = longint'((longint'(r) * 652032874 + 32768) >>> 16);
    cy = 0;
    z = theta;
    // Rotation stages with floor shifts.
    for (int i = 0; i < 16; i++) begin
      ang = (i < 10) ? atan_tab[i] : (longint'(1) << (30 - i));
      tx = cx >>> i;
      ty = cy >>> i;
      if (z >= 0) begin
        cx = cx - ty; cy = cy + tx; z = z - ang;
      end else begin
        cx = cx + ty; cy = cy - tx; z = z + ang;
      end
    end
    cx = (cx + 8192) >>> 14;
    cy = (cy + 8192) >>> 14;
    case (turns)
      1: begin ox = -cy; oy = cx; end
      2: begin ox = -cx; oy = -cy; end
      3: begin ox = cy; oy = -cx; end
      default: begin ox = cx; oy = cy; end
    endcase
    p.dx = 18'(clamp_one(ox));
    p.dy = 18'(clamp_one(oy));
    p.last = lst;
    return p;
  endfunction

  // Offers one request and waits until it is taken.
  task automatic send_sample(logic [16:0] sx, logic [16:0] sy, logic lst,
                             bit typed, disk_pt_t typed_pt);
    if (send_gaps && !quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    square_x <= sx;
    square_y <= sy;
    last_sample <= lst;
    do @(posedge clk); while (in_stall);
    if (typed) pending_pts.push_back(typed_pt);
    else pending_pts.push_back(map_point(sx, sy, lst, zero_limit));
  endtask

  // Writes the limit once the block has drained.
  task automatic write_limit(logic [7:0] v);
    in_valid <= 1'b0;
    wait (pending_pts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    near_zero_limit_we <= 1'b1;
    near_zero_limit_data <= v;
    @(posedge clk);
    near_zero_limit_we <= 1'b0;
    zero_limit = v;
  endtask

  // Random sample, biased toward diagonals, the centre and near-zero y.
  task automatic send_random();
    logic [16:0] sx, sy;
    int k;
    k = int'($urandom_range(9));
    case (k)
      0: begin
        sx = 17'($urandom_range(131071));
        sy = 17'($urandom_range(131071));
      end
      1: begin sx = 17'($urandom_range(65536)); sy = sx; end
      2: begin sx = 17'($urandom_range(65536)); sy = 17'(65536 - int'(sx)); end
      3, 4: begin
        sx = 17'($urandom_range(32768));
        sy = 17'(32768 + int'($urandom_range(140)) - 70);
      end
      5: begin
        sx = 17'(32768 + int'($urandom_range(8)) - 4);
        sy = 17'(32768 + int'($urandom_range(8)) - 4);
      end
      default: begin
        sx = 17'($urandom_range(65536));
        sy = 17'($urandom_range(65536));
      end
    endcase
    send_sample(sx, sy, 1'($urandom_range(1)), 1'b0, '{default: '0});
  endtask

  // Receiver stalls: random bursts, one long hold, none in the quiet part.
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(5, 1)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Checks each delivered point against the oldest expectation.
  always @(posedge clk) begin
    disk_pt_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", $signed(disk_x), $signed(disk_y));
        fail_count++;
      end else begin
        e = pending_pts.pop_front();
        if ($signed(disk_x) !== e.dx) begin
          $error("disk_x expected %0d actual %0d", e.dx, $signed(disk_x));
          fail_count++;
        end
        if ($signed(disk_y) !== e.dy) begin
          $error("disk_y expected %0d actual %0d", e.dy, $signed(disk_y));
          fail_count++;
        end
        if (last_out !== e.last) begin
          $error("last_out expected %0d actual %0d", e.last, last_out);
          fail_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    sample_row_t rows[$];
    logic [7:0] limits[5];
    disk_pt_t tp;
    rows = '{
      '{17'd32768, 17'd32768, 1'b0, 1'b1, 18'sd0, 18'sd0},
      '{17'd0, 17'd0, 1'b0, 1'b0, 0, 0},
      '{17'd65536, 17'd65536, 1'b1, 1'b0, 0, 0},
      '{17'd0, 17'd65536, 1'b0, 1'b0, 0, 0},
      '{17'd65536, 17'd0, 1'b1, 1'b0, 0, 0},
      '{17'd131071, 17'd131071, 1'b0, 1'b0, 0, 0},
      '{17'd65537, 17'd0, 1'b1, 1'b0, 0, 0},
      '{17'd0, 17'd98304, 1'b0, 1'b0, 0, 0},
      '{17'd65536, 17'd32768, 1'b0, 1'b0, 0, 0},
      '{17'd32768, 17'd65536, 1'b1, 1'b0, 0, 0},
      '{17'd0, 17'd32768, 1'b0, 1'b0, 0, 0},
      '{17'd32768, 17'd0, 1'b0, 1'b0, 0, 0},
      '{17'd49152, 17'd49152, 1'b0, 1'b0, 0, 0},
      '{17'd49152, 17'd16384, 1'b1, 1'b0, 0, 0},
      '{17'd16384, 17'd16384, 1'b0, 1'b0, 0, 0},
      '{17'd16384, 17'd49152, 1'b0, 1'b0, 0, 0},
      '{17'd32767, 17'd32768, 1'b0, 1'b0, 0, 0},
      '{17'd32768, 17'd32767, 1'b1, 1'b0, 0, 0},
      '{17'd32769, 17'd32768, 1'b0, 1'b0, 0, 0},
      '{17'd1, 17'd1, 1'b0, 1'b0, 0, 0},
      '{17'd65535, 17'd1, 1'b0, 1'b0, 0, 0},
      '{17'd10000, 17'd32769, 1'b1, 1'b0, 0, 0},
      '{17'd100000, 17'd20000, 1'b0, 1'b0, 0, 0}
    };
    limits = '{8'd255, 8'd0, 8'd1, 8'($urandom_range(255)), 8'd128};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the reset value of the limit.
    foreach (rows[i]) begin
      tp.dx = rows[i].ex;
      tp.dy = rows[i].ey;
      tp.last = rows[i].last;
      send_sample(rows[i].sx, rows[i].sy, rows[i].last, rows[i].typed, tp);
    end

    // Random phases, one per limit setting.
    foreach (limits[p]) begin
      write_limit(limits[p]);
      if (p == 4) quiet = 1'b1;
      for (int n = 0; n < 240; n++) begin
        if (p == 1 && n == 40) hold_req = 1'b1;
        if (p == 2 && n == 100) begin
          in_valid <= 1'b0;
          wait (pending_pts.size() == 0);
          @(posedge clk);
        end
        send_random();
      end
    end
    in_valid <= 1'b0;

    wait (pending_pts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
